FILE: rtl/core/mmc3ob_pkg.sv
// ----------------------------------------------------------------------------
// mmc3ob_pkg
// Types, register codes and the sequencer program of the MMC3 outer bank mapper.
// ----------------------------------------------------------------------------
package mmc3ob_pkg;

    // ---------------- transfer payloads ----------------
    typedef enum logic [1:0] {
        OP_CPU     = 2'd0,
        OP_OUTER   = 2'd1,
        OP_TICK    = 2'd2,
        OP_REFRESH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_PRG8   = 3'd0,
        K_PRG32  = 3'd1,
        K_CHR    = 3'd2,
        K_MIRROR = 3'd3,
        K_RAISE  = 3'd4,
        K_CLEAR  = 3'd5,
        K_NONE   = 3'd6
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [15:0] address;
        logic [7:0]  data;
        logic        rendering_on;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] slot;
        logic [7:0] value;
        logic       last;
    } t_out_item;

    // ---------------- configuration ----------------
    localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

    localparam logic [7:0] PRG_COUNT_RST = 8'd32;
    localparam logic [7:0] CHR_COUNT_RST = 8'd128;

    // ---------------- CPU register decode ----------------
    localparam logic [15:0] ADDR_MASK   = 16'hE001;
    localparam logic [15:0] A_SELECT    = 16'h8000;
    localparam logic [15:0] A_BANK      = 16'h8001;
    localparam logic [15:0] A_MIRROR    = 16'hA000;
    localparam logic [15:0] A_LATCH     = 16'hC000;
    localparam logic [15:0] A_RELOAD    = 16'hC001;
    localparam logic [15:0] A_IRQ_OFF   = 16'hE000;
    localparam logic [15:0] A_IRQ_ON    = 16'hE001;

    localparam logic [1:0] OREG_PRG_OFS = 2'd0;
    localparam logic [1:0] OREG_CHR_OFS = 2'd1;
    localparam logic [1:0] OREG_MODE    = 2'd2;

    // ---------------- microcode ----------------
    localparam int UPC_W = 5;

    localparam logic [UPC_W-1:0] UA_IDLE   = 5'd0;
    localparam logic [UPC_W-1:0] UA_SINGLE = 5'd1;
    localparam logic [UPC_W-1:0] UA_MAP    = 5'd2;
    localparam logic [UPC_W-1:0] UA_CHR    = 5'd16;
    localparam logic [UPC_W-1:0] UA_PRG32  = 5'd21;

    typedef enum logic [2:0] {
        CMD_WAIT = 3'd0,
        CMD_JUMP = 3'd1,
        CMD_MODA = 3'd2,
        CMD_MODB = 3'd3,
        CMD_MODC = 3'd4,
        CMD_EMIT = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        COND_NEXT      = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_MODE32    = 3'd2,
        COND_CHR_ZERO  = 3'd3,
        COND_SLOT_MORE = 3'd4
    } t_cond;

    typedef enum logic [1:0] {
        SRC_B6   = 2'd0,
        SRC_B7   = 2'd1,
        SRC_OPF4 = 2'd2,
        SRC_CHR  = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        CNT_PRG  = 2'd0,
        CNT_PRG4 = 2'd1,
        CNT_CHR  = 2'd2
    } t_cnt;

    typedef enum logic [2:0] {
        VAL_MOD          = 3'd0,
        VAL_MOD_OR_SLAST = 3'd1,
        VAL_SLAST_OR_MOD = 3'd2,
        VAL_LASTB        = 3'd3,
        VAL_SINGLE       = 3'd4
    } t_vsel;

    typedef enum logic [1:0] {
        LAST_NO    = 2'd0,
        LAST_YES   = 2'd1,
        LAST_NOCHR = 2'd2,
        LAST_SLOT7 = 2'd3
    } t_lastm;

    typedef struct packed {
        t_cmd             cmd;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        t_kind            kind;
        logic [2:0]       slot;
        logic             slot_ctr;
        t_src             src;
        t_cnt             cnt;
        t_vsel            vsel;
        t_lastm           lastm;
    } t_uword;

    function automatic t_uword mk_uw(
        input t_cmd             cmd,
        input t_cond            cond,
        input logic [UPC_W-1:0] target,
        input t_kind            kind,
        input logic [2:0]       slot,
        input logic             slot_ctr,
        input t_src             src,
        input t_cnt             cnt,
        input t_vsel            vsel,
        input t_lastm           lastm
    );
        t_uword w;
        w.cmd      = cmd;
        w.cond     = cond;
        w.target   = target;
        w.kind     = kind;
        w.slot     = slot;
        w.slot_ctr = slot_ctr;
        w.src      = src;
        w.cnt      = cnt;
        w.vsel     = vsel;
        w.lastm    = lastm;
        return w;
    endfunction

    // Shorthands for steps whose extra fields do not matter
    function automatic t_uword uw_jump(input t_cond cond, input logic [UPC_W-1:0] target);
        return mk_uw(CMD_JUMP, cond, target, K_NONE, 3'd0, 1'b0,
                     SRC_B6, CNT_PRG, VAL_MOD, LAST_NO);
    endfunction

    function automatic t_uword uw_mod(input t_cmd cmd, input t_src src, input t_cnt cnt);
        return mk_uw(cmd, COND_NEXT, UA_IDLE, K_NONE, 3'd0, 1'b0,
                     src, cnt, VAL_MOD, LAST_NO);
    endfunction

    function automatic t_uword uw_emit(
        input t_cond            cond,
        input logic [UPC_W-1:0] target,
        input t_kind            kind,
        input logic [2:0]       slot,
        input logic             slot_ctr,
        input t_vsel            vsel,
        input t_lastm           lastm
    );
        return mk_uw(CMD_EMIT, cond, target, kind, slot, slot_ctr,
                     SRC_B6, CNT_PRG, vsel, lastm);
    endfunction

    // Program: dispatch, single result, PRG 8K run, CHR loop, PRG 32K run
    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        unique case (addr)
            5'd0:  w = mk_uw(CMD_WAIT, COND_NEXT, UA_IDLE, K_NONE, 3'd0, 1'b0,
                             SRC_B6, CNT_PRG, VAL_MOD, LAST_NO);
            5'd1:  w = uw_emit(COND_ALWAYS, UA_IDLE, K_NONE, 3'd0, 1'b0,
                               VAL_SINGLE, LAST_YES);
            5'd2:  w = uw_jump(COND_MODE32, UA_PRG32);
            // PRG slot 0
            5'd3:  w = uw_mod(CMD_MODA, SRC_B6, CNT_PRG);
            5'd4:  w = uw_mod(CMD_MODB, SRC_B6, CNT_PRG);
            5'd5:  w = uw_mod(CMD_MODC, SRC_B6, CNT_PRG);
            5'd6:  w = uw_emit(COND_NEXT, UA_IDLE, K_PRG8, 3'd0, 1'b0,
                               VAL_MOD_OR_SLAST, LAST_NO);
            // PRG slot 1
            5'd7:  w = uw_mod(CMD_MODA, SRC_B7, CNT_PRG);
            5'd8:  w = uw_mod(CMD_MODB, SRC_B7, CNT_PRG);
            5'd9:  w = uw_mod(CMD_MODC, SRC_B7, CNT_PRG);
            5'd10: w = uw_emit(COND_NEXT, UA_IDLE, K_PRG8, 3'd1, 1'b0,
                               VAL_MOD, LAST_NO);
            // PRG slot 2
            5'd11: w = uw_mod(CMD_MODA, SRC_B6, CNT_PRG);
            5'd12: w = uw_mod(CMD_MODB, SRC_B6, CNT_PRG);
            5'd13: w = uw_mod(CMD_MODC, SRC_B6, CNT_PRG);
            5'd14: w = uw_emit(COND_NEXT, UA_IDLE, K_PRG8, 3'd2, 1'b0,
                               VAL_SLAST_OR_MOD, LAST_NO);
            // PRG slot 3, fixed last bank
            5'd15: w = uw_emit(COND_CHR_ZERO, UA_IDLE, K_PRG8, 3'd3, 1'b0,
                               VAL_LASTB, LAST_NOCHR);
            // CHR loop over slots 0-7
            5'd16: w = uw_mod(CMD_MODA, SRC_CHR, CNT_CHR);
            5'd17: w = uw_mod(CMD_MODB, SRC_CHR, CNT_CHR);
            5'd18: w = uw_mod(CMD_MODC, SRC_CHR, CNT_CHR);
            5'd19: w = uw_emit(COND_SLOT_MORE, UA_CHR, K_CHR, 3'd0, 1'b1,
                               VAL_MOD, LAST_SLOT7);
            5'd20: w = uw_jump(COND_ALWAYS, UA_IDLE);
            // PRG 32K
            5'd21: w = uw_mod(CMD_MODA, SRC_OPF4, CNT_PRG4);
            5'd22: w = uw_mod(CMD_MODB, SRC_OPF4, CNT_PRG4);
            5'd23: w = uw_mod(CMD_MODC, SRC_OPF4, CNT_PRG4);
            5'd24: w = uw_emit(COND_CHR_ZERO, UA_IDLE, K_PRG32, 3'd0, 1'b0,
                               VAL_MOD, LAST_NOCHR);
            5'd25: w = uw_jump(COND_ALWAYS, UA_CHR);
            default: w = uw_jump(COND_ALWAYS, UA_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/mmc3_outer_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// mmc3_outer_bank_mapper_core
// MMC3-style bank mapper with outer PRG/CHR offsets, run by a microcoded
// sequencer; emits the resulting slot mapping as a run of results.
// ----------------------------------------------------------------------------
// Latency/throughput: an input is taken only when the sequencer sits at its
//   idle step, so a new input waits until the run before it is back there.
//   A single result needs only its emit step; a banked result needs a load
//   with the first of 3 steps of the 3-bit-per-cycle remainder unit, 2 more, then emit.
// Output stalls hold the sequencer on its emit step; one result register.
// Reset (i_rst_n low, synchronous): sequencer idle, output empty, mapper
//   registers and configuration back to their power-on values.
// ----------------------------------------------------------------------------
module mmc3_outer_bank_mapper_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data,
    // input items
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  mmc3ob_pkg::t_in_item   i_in_item,
    // result items
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output mmc3ob_pkg::t_out_item  o_out_item
);
    import mmc3ob_pkg::*;

    // ---------------- configuration ----------------
    logic [7:0] r_prg_count;
    logic [7:0] r_chr_count;
    logic       r_four_screen;

    // ---------------- mapper state ----------------
    logic [7:0] r_select;
    logic [7:0] r_bank [8];
    logic       r_mirror;
    logic [7:0] r_irq_latch;
    logic [7:0] r_irq_count;
    logic       r_irq_reload;
    logic       r_irq_enable;
    logic [5:0] r_prg_ofs;
    logic [5:0] r_chr_ofs;
    logic       r_mode32;       // only bit 7 of the mode register matters

    // ---------------- sequencer ----------------
    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic [2:0]       r_slot;   // CHR slot counter

    // remainder unit
    logic [5:0] r_dvd;          // low dividend bits still to shift in
    logic [8:0] r_rem;
    logic [7:0] r_div;

    // single-result kind captured at dispatch
    t_kind      r_single_kind;

    // output register
    logic       r_out_valid;
    t_out_item  r_out_item;

    assign uw = ucode_rom(r_upc);

    // ---------------- dispatch decode ----------------
    logic       in_xfer;
    logic [15:0] cpu_dec;
    logic       s_map;
    t_kind      s_kind;
    logic [7:0] tick_count;

    assign o_in_ready = (uw.cmd == CMD_WAIT);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign cpu_dec    = i_in_item.address & ADDR_MASK;

    // IRQ counter value after a tick with rendering on
    assign tick_count = ((r_irq_count == 8'd0) || r_irq_reload) ? r_irq_latch
                                                                : r_irq_count - 8'd1;

    always_comb begin
        s_map  = 1'b0;
        s_kind = K_NONE;
        unique case (i_in_item.op)
            OP_CPU: begin
                case (cpu_dec)
                    A_SELECT, A_BANK: s_map = 1'b1;
                    A_MIRROR:         s_kind = r_four_screen ? K_NONE : K_MIRROR;
                    A_IRQ_OFF:        s_kind = K_CLEAR;
                    default:          s_kind = K_NONE;
                endcase
            end
            OP_OUTER: begin
                s_map = (i_in_item.address[1:0] != 2'd3);
            end
            OP_TICK: begin
                if (i_in_item.rendering_on && (tick_count == 8'd0) && r_irq_enable) begin
                    s_kind = K_RAISE;
                end
            end
            OP_REFRESH: begin
                s_map = 1'b1;
            end
            default: s_map = 1'b0;
        endcase
    end

    // ---------------- datapath operands ----------------
    logic [2:0] chr_j;       // CHR source index after the A12 swap
    logic [2:0] bank_idx;
    logic [7:0] bank_val;
    logic [7:0] chr_bank;
    logic [8:0] operand;
    logic [7:0] count_sel;
    logic [7:0] slast;
    logic [7:0] lastb;
    logic [7:0] mod_val;

    assign chr_j = r_slot ^ {r_select[7], 2'b00};

    always_comb begin
        unique case (uw.src)
            SRC_B6:  bank_idx = 3'd6;
            SRC_B7:  bank_idx = 3'd7;
            SRC_CHR: bank_idx = chr_j[2] ? (chr_j - 3'd2) : {2'b00, chr_j[1]};
            default: bank_idx = 3'd0;
        endcase
    end

    assign bank_val = r_bank[bank_idx];
    // 2K pairs: even half has bit 0 cleared, odd half has it set
    assign chr_bank = chr_j[2] ? bank_val : {bank_val[7:1], chr_j[0]};

    always_comb begin
        unique case (uw.src)
            SRC_B6, SRC_B7: operand = {3'b000, r_prg_ofs} + {1'b0, bank_val};
            SRC_OPF4:       operand = {5'b00000, r_prg_ofs[5:2]};
            SRC_CHR:        operand = {3'b000, r_chr_ofs} + {1'b0, chr_bank};
            default:        operand = 9'd0;
        endcase
    end

    always_comb begin
        unique case (uw.cnt)
            CNT_PRG:  count_sel = r_prg_count;
            CNT_PRG4: count_sel = {2'b00, r_prg_count[7:2]};
            CNT_CHR:  count_sel = r_chr_count;
            default:  count_sel = 8'd0;
        endcase
    end

    // Three restoring remainder steps; a zero divisor is masked at emit
    function automatic logic [8:0] rem_step3(
        input logic [8:0] rem,
        input logic [2:0] bits,
        input logic [7:0] div
    );
        logic [8:0] r;
        r = rem;
        for (int k = 2; k >= 0; k--) begin
            r = {r[7:0], bits[k]};
            if (r >= {1'b0, div}) begin
                r = r - {1'b0, div};
            end
        end
        return r;
    endfunction

    assign slast   = r_prg_count - 8'd2;
    assign lastb   = r_prg_count - 8'd1;
    assign mod_val = (r_div == 8'd0) ? 8'd0 : r_rem[7:0];

    // ---------------- result assembly ----------------
    t_out_item emit_item;
    logic      can_emit;

    assign can_emit = !r_out_valid || i_out_ready;

    always_comb begin
        emit_item.kind = uw.kind;
        emit_item.slot = uw.slot_ctr ? r_slot : uw.slot;
        unique case (uw.vsel)
            VAL_MOD:          emit_item.value = mod_val;
            VAL_MOD_OR_SLAST: emit_item.value = r_select[6] ? slast : mod_val;
            VAL_SLAST_OR_MOD: emit_item.value = r_select[6] ? mod_val : slast;
            VAL_LASTB:        emit_item.value = lastb;
            VAL_SINGLE: begin
                emit_item.kind  = r_single_kind;
                // mirroring result carries the newly written bit
                emit_item.value = (r_single_kind == K_MIRROR) ? {7'd0, r_mirror} : 8'd0;
            end
            default:          emit_item.value = 8'd0;
        endcase
        unique case (uw.lastm)
            LAST_NO:    emit_item.last = 1'b0;
            LAST_YES:   emit_item.last = 1'b1;
            LAST_NOCHR: emit_item.last = (r_chr_count == 8'd0);
            LAST_SLOT7: emit_item.last = (r_slot == 3'd7);
            default:    emit_item.last = 1'b0;
        endcase
    end

    // ---------------- step counter ----------------
    logic advance;
    logic cond_ok;

    always_comb begin
        unique case (uw.cond)
            COND_NEXT:      cond_ok = 1'b0;
            COND_ALWAYS:    cond_ok = 1'b1;
            COND_MODE32:    cond_ok = r_mode32;
            COND_CHR_ZERO:  cond_ok = (r_chr_count == 8'd0);
            COND_SLOT_MORE: cond_ok = (r_slot != 3'd7);
            default:        cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_upc   = r_upc;
        advance = 1'b0;
        unique case (uw.cmd)
            CMD_WAIT: begin
                if (in_xfer) begin
                    n_upc = s_map ? UA_MAP : UA_SINGLE;
                end
            end
            CMD_EMIT: advance = can_emit;
            default:  advance = 1'b1;
        endcase
        if (advance) begin
            n_upc = cond_ok ? uw.target : r_upc + 1'b1;
        end
    end

    // ---------------- control and mapper registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc         <= UA_IDLE;
            r_slot        <= 3'd0;
            r_out_valid   <= 1'b0;
            r_prg_count   <= PRG_COUNT_RST;
            r_chr_count   <= CHR_COUNT_RST;
            r_four_screen <= 1'b0;
            r_select      <= 8'd0;
            for (int i = 0; i < 8; i++) begin
                r_bank[i] <= 8'd0;
            end
            r_bank[7]     <= 8'd1;
            r_mirror      <= 1'b0;
            r_irq_latch   <= 8'd0;
            r_irq_count   <= 8'd0;
            r_irq_reload  <= 1'b0;
            r_irq_enable  <= 1'b0;
            r_prg_ofs     <= 6'd0;
            r_chr_ofs     <= 6'd0;
            r_mode32      <= 1'b0;
        end else begin
            r_upc <= n_upc;

            // configuration, to be written by the user only while idle; the block does not enforce this
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRG_COUNT:   r_prg_count   <= i_cfg_data;
                    CFG_CHR_COUNT:   r_chr_count   <= i_cfg_data;
                    CFG_FOUR_SCREEN: r_four_screen <= i_cfg_data[0];
                    default:         ;
                endcase
            end

            // mapper register writes at dispatch
            if (in_xfer) begin
                r_slot <= 3'd0;
                unique case (i_in_item.op)
                    OP_CPU: begin
                        case (cpu_dec)
                            A_SELECT:  r_select <= i_in_item.data;
                            A_BANK:    r_bank[r_select[2:0]] <= i_in_item.data;
                            A_MIRROR:  r_mirror <= i_in_item.data[0];
                            A_LATCH:   r_irq_latch <= i_in_item.data;
                            A_RELOAD:  r_irq_reload <= 1'b1;
                            A_IRQ_OFF: r_irq_enable <= 1'b0;
                            A_IRQ_ON:  r_irq_enable <= 1'b1;
                            default:   ;
                        endcase
                    end
                    OP_OUTER: begin
                        case (i_in_item.address[1:0])
                            OREG_PRG_OFS: r_prg_ofs <= i_in_item.data[5:0];
                            OREG_CHR_OFS: r_chr_ofs <= i_in_item.data[5:0];
                            OREG_MODE:    r_mode32  <= i_in_item.data[7];
                            default:      ;
                        endcase
                    end
                    OP_TICK: begin
                        if (i_in_item.rendering_on) begin
                            r_irq_count  <= tick_count;
                            r_irq_reload <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            // output register
            if (uw.cmd == CMD_EMIT && can_emit) begin
                r_out_valid <= 1'b1;
                if (uw.slot_ctr) begin
                    r_slot <= r_slot + 3'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_single_kind <= s_kind;
        end
        unique case (uw.cmd)
            CMD_MODA: begin
                r_dvd <= operand[5:0];
                r_div <= count_sel;
                r_rem <= rem_step3(9'd0, operand[8:6], count_sel);
            end
            CMD_MODB: r_rem <= rem_step3(r_rem, r_dvd[5:3], r_div);
            CMD_MODC: r_rem <= rem_step3(r_rem, r_dvd[2:0], r_div);
            default:  ;
        endcase
        if (uw.cmd == CMD_EMIT && can_emit) begin
            r_out_item <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- assertions ----------------
    // the sequencer leaves the idle step right after taking an input
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("sequencer still idle after input transfer");

    // back at idle, any pending result must close its run
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && o_out_valid) |-> o_out_item.last)
        else $error("idle with an unfinished result run");

    // a CHR result closes the run only on slot 7
    a_chr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == K_CHR && o_out_item.last)
            |-> (o_out_item.slot == 3'd7))
        else $error("CHR run ended before slot 7");

    // remainder unit leaves a value below its divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.cmd == CMD_EMIT && r_div != 8'd0
            && (uw.vsel == VAL_MOD || uw.vsel == VAL_MOD_OR_SLAST
                || uw.vsel == VAL_SLAST_OR_MOD))
            |-> (r_rem < {1'b0, r_div}))
        else $error("remainder not reduced below bank count");

endmodule
